/* rtl/point_to_line_ray_segment_sqr_distance_macros.svh */
// ---------------------------------------------------------------------------
// Point to line, ray or segment squared distance: assertion macros
// Shared concurrent assertion forms for the checker.
// ---------------------------------------------------------------------------
`ifndef POINT_TO_LINE_RAY_SEGMENT_SQR_DISTANCE_MACROS_SVH
`define POINT_TO_LINE_RAY_SEGMENT_SQR_DISTANCE_MACROS_SVH

// Same-cycle implication.
`define PTLRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication.
`define PTLRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/ptlrs_pkg.sv */
// ---------------------------------------------------------------------------
// Point to line, ray or segment squared distance: package
// Widths, codes and stage payload types shared by the pipeline modules.
// ---------------------------------------------------------------------------
package ptlrs_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PROD_W = DIFF_W + COORD_WIDTH;
  localparam int DOT_W  = PROD_W + 2;
  localparam int LEN_W  = 2 * COORD_WIDTH;
  localparam int NUM_W  = DOT_W + FRAC_BITS + 1;

  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = (COORD_WIDTH + 1 + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_ITER   = DIV_STAGES * DIV_STEPS;

  localparam int TQ_W  = DIV_ITER + FRAC_BITS + 2;
  localparam int RES_W = ((2 * COORD_WIDTH > DIFF_W + FRAC_BITS) ?
                          2 * COORD_WIDTH : DIFF_W + FRAC_BITS) + 1;
  localparam int SQ_W    = 64;
  localparam int SQ_HALF = SQ_W / 2;
  localparam int MAG_W   = (RES_W > SQ_W + 1) ? RES_W : SQ_W + 1;
  localparam int ACC_W   = 2 * SQ_W + 2;

  localparam int FRONT_STAGES = 4;
  localparam int DIST_STAGES  = 6;
  localparam int N_STAGES     = FRONT_STAGES + DIV_STAGES + 1 + DIST_STAGES;

  localparam logic [1:0] KIND_LINE = 2'd0;
  localparam logic [1:0] KIND_RAY  = 2'd1;

  typedef enum logic [1:0] {
    TSRC_ZERO = 2'd0,
    TSRC_ONE  = 2'd1,
    TSRC_DIV  = 2'd2
  } tsrc_e;

  typedef struct packed {
    logic [1:0]                    kind;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic signed [COORD_WIDTH-1:0] origin_x;
    logic signed [COORD_WIDTH-1:0] origin_y;
    logic signed [COORD_WIDTH-1:0] origin_z;
    logic signed [COORD_WIDTH-1:0] dir_x;
    logic signed [COORD_WIDTH-1:0] dir_y;
    logic signed [COORD_WIDTH-1:0] dir_z;
  } in_t;

  typedef struct packed {
    logic [SQ_W-1:0]               sqr_dist;
    logic signed [COORD_WIDTH-1:0] param_t;
    logic                          zero_direction;
    logic                          saturated;
  } out_t;

  typedef struct packed {
    logic [2:0][DIFF_W-1:0]      diff;
    logic [2:0][COORD_WIDTH-1:0] dir;
  } geo_t;

  typedef struct packed {
    tsrc_e src;
    logic  neg;
    logic  ovf;
    logic  zero_dir;
  } tctl_t;

  typedef struct packed {
    logic [LEN_W-1:0]    rem;
    logic [LEN_W-1:0]    den;
    logic [DIV_ITER-1:0] num;
    logic [DIV_ITER-1:0] quo;
    tctl_t               ctl;
    geo_t                geo;
  } div_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] tq;
    logic                          tsat;
    logic                          zero_dir;
  } meta_t;

  typedef struct packed {
    meta_t meta;
    geo_t  geo;
  } tpar_t;

endpackage

/* rtl/ptlrs_front.sv */
// ---------------------------------------------------------------------------
// Front stages
// Offsets, dot products, squared length and parameter source selection.
// ---------------------------------------------------------------------------
module ptlrs_front import ptlrs_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  in_t  in_i,
  output div_t div_o
);

  logic signed [COORD_WIDTH-1:0] pt  [3];
  logic signed [COORD_WIDTH-1:0] org [3];
  logic signed [COORD_WIDTH-1:0] dr  [3];

  geo_t       geo1_d, geo1_q, geo2_q, geo3_q;
  logic [1:0] kind1_q, kind2_q, kind3_q;

  logic [2:0][PROD_W-1:0] pdot_d, pdot_q;
  logic [2:0][LEN_W-1:0]  plen_d, plen_q;

  logic signed [DOT_W-1:0] dot_d, dot_q;
  logic [LEN_W-1:0]        len_d, len_q;

  div_t div_d, div_q;

  assign pt[0]  = in_i.point_x;
  assign pt[1]  = in_i.point_y;
  assign pt[2]  = in_i.point_z;
  assign org[0] = in_i.origin_x;
  assign org[1] = in_i.origin_y;
  assign org[2] = in_i.origin_z;
  assign dr[0]  = in_i.dir_x;
  assign dr[1]  = in_i.dir_y;
  assign dr[2]  = in_i.dir_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      geo1_d.diff[i] = DIFF_W'(pt[i]) - DIFF_W'(org[i]);
      geo1_d.dir[i]  = dr[i];
    end
  end

  always_comb begin
    logic signed [DIFF_W-1:0]      ds;
    logic signed [COORD_WIDTH-1:0] vs;
    logic signed [PROD_W-1:0]      pd;
    logic signed [LEN_W-1:0]       pl;
    for (int i = 0; i < 3; i++) begin
      ds        = $signed(geo1_q.diff[i]);
      vs        = $signed(geo1_q.dir[i]);
      pd        = ds * vs;
      pl        = vs * vs;
      pdot_d[i] = pd;
      plen_d[i] = pl;
    end
  end

  always_comb begin
    dot_d = DOT_W'($signed(pdot_q[0])) + DOT_W'($signed(pdot_q[1]))
          + DOT_W'($signed(pdot_q[2]));
    len_d = plen_q[0] + plen_q[1] + plen_q[2];
  end

  always_comb begin
    logic [DOT_W-1:0] dmag;
    logic [NUM_W-1:0] num2;
    logic             dot_neg, dot_pos, len_zero, is_line;
    dot_neg  = dot_q[DOT_W-1];
    dot_pos  = !dot_neg && (dot_q != '0);
    len_zero = (len_q == '0);
    is_line  = (kind3_q == KIND_LINE);
    dmag     = dot_neg ? DOT_W'(-dot_q) : DOT_W'(dot_q);
    num2     = {dmag, {(FRAC_BITS + 1){1'b0}}};

    div_d.rem = LEN_W'(num2 >> DIV_ITER);
    div_d.den = len_q;
    div_d.num = num2[DIV_ITER-1:0];
    div_d.quo = '0;
    div_d.geo = geo3_q;
    div_d.ctl.ovf      = (num2 >> (COORD_WIDTH + 1)) >= NUM_W'(len_q);
    div_d.ctl.zero_dir = is_line && len_zero;
    div_d.ctl.neg      = is_line && dot_neg;
    if (is_line) begin
      div_d.ctl.src = len_zero ? TSRC_ZERO : TSRC_DIV;
    end else if (dot_pos) begin
      if ((kind3_q != KIND_RAY) && (DOT_W'(len_q) <= $unsigned(dot_q))) begin
        div_d.ctl.src = TSRC_ONE;
      end else begin
        div_d.ctl.src = TSRC_DIV;
      end
    end else begin
      div_d.ctl.src = TSRC_ZERO;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geo1_q  <= geo1_d;
      kind1_q <= in_i.kind;
      pdot_q  <= pdot_d;
      plen_q  <= plen_d;
      geo2_q  <= geo1_q;
      kind2_q <= kind1_q;
      dot_q   <= dot_d;
      len_q   <= len_d;
      geo3_q  <= geo2_q;
      kind3_q <= kind2_q;
      div_q   <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

/* rtl/ptlrs_div_stage.sv */
// ---------------------------------------------------------------------------
// Divider stage
// A few restoring division steps of the parameter quotient, registered.
// ---------------------------------------------------------------------------
module ptlrs_div_stage import ptlrs_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  div_t div_i,
  output div_t div_o
);

  div_t div_d, div_q;

  always_comb begin
    logic [LEN_W:0]      trial;
    logic [LEN_W-1:0]    rem;
    logic [DIV_ITER-1:0] num;
    logic [DIV_ITER-1:0] quo;
    rem = div_i.rem;
    num = div_i.num;
    quo = div_i.quo;
    for (int s = 0; s < DIV_STEPS; s++) begin
      trial = {rem, num[DIV_ITER-1]};
      num   = {num[DIV_ITER-2:0], 1'b0};
      if (trial >= {1'b0, div_i.den}) begin
        rem = LEN_W'(trial - {1'b0, div_i.den});
        quo = {quo[DIV_ITER-2:0], 1'b1};
      end else begin
        rem = trial[LEN_W-1:0];
        quo = {quo[DIV_ITER-2:0], 1'b0};
      end
    end
    div_d     = div_i;
    div_d.rem = rem;
    div_d.num = num;
    div_d.quo = quo;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

/* rtl/ptlrs_tclip.sv */
// ---------------------------------------------------------------------------
// Parameter rounding and clipping
// Rounds the quotient, applies sign and saturates to the parameter range.
// ---------------------------------------------------------------------------
module ptlrs_tclip import ptlrs_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  div_t  div_i,
  output tpar_t tpar_o
);

  tpar_t tpar_d, tpar_q;

  always_comb begin
    logic [TQ_W-1:0] rnd, lim, val, mag;
    logic            sat;
    rnd = (TQ_W'(div_i.quo) + TQ_W'(1)) >> 1;
    lim = (TQ_W'(1) << (COORD_WIDTH - 1)) - (div_i.ctl.neg ? TQ_W'(0) : TQ_W'(1));
    sat = 1'b0;
    val = '0;
    case (div_i.ctl.src)
      TSRC_ONE: begin
        val = TQ_W'(1) << FRAC_BITS;
        sat = val > lim;
      end
      TSRC_DIV: begin
        val = rnd;
        sat = div_i.ctl.ovf || (val > lim);
      end
      default: begin
        val = '0;
        sat = 1'b0;
      end
    endcase
    mag = sat ? lim : val;
    tpar_d.meta.tq       = COORD_WIDTH'(div_i.ctl.neg ? -mag : mag);
    tpar_d.meta.tsat     = sat;
    tpar_d.meta.zero_dir = div_i.ctl.zero_dir;
    tpar_d.geo           = div_i.geo;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tpar_q <= tpar_d;
    end
  end

  assign tpar_o = tpar_q;

endmodule

/* rtl/ptlrs_dist.sv */
// ---------------------------------------------------------------------------
// Distance stages
// Residual vector, split squaring, accumulation, rounding and saturation.
// ---------------------------------------------------------------------------
module ptlrs_dist import ptlrs_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  tpar_t tpar_i,
  output out_t  out_o
);

  localparam int RBIT = (FRAC_BITS > 0) ? 2 * FRAC_BITS - 1 : 0;

  logic [2:0][LEN_W-1:0]   prod_d, prod_q;
  tpar_t                   tpar1_q;
  logic [2:0][SQ_W-1:0]    mag_d, mag_q;
  logic                    ovf2_d, ovf2_q, ovf3_q, ovf4_q, ovf5_q;
  meta_t                   meta2_q, meta3_q, meta4_q, meta5_q;
  logic [2:0][SQ_W-1:0]    ll_d, ll_q, lh_d, lh_q, hh_d, hh_q;
  logic [2:0][2*SQ_W-1:0]  sq_d, sq_q;
  logic [ACC_W-1:0]        acc_d, acc_q;
  out_t                    out_d, out_q;

  always_comb begin
    logic signed [COORD_WIDTH-1:0] ts, vs;
    logic signed [LEN_W-1:0]       p;
    ts = tpar_i.meta.tq;
    for (int i = 0; i < 3; i++) begin
      vs        = $signed(tpar_i.geo.dir[i]);
      p         = ts * vs;
      prod_d[i] = p;
    end
  end

  always_comb begin
    logic signed [RES_W-1:0] r;
    logic signed [MAG_W-1:0] rx;
    logic [MAG_W-1:0]        m;
    ovf2_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      r  = (RES_W'($signed(tpar1_q.geo.diff[i])) <<< FRAC_BITS)
         - RES_W'($signed(prod_q[i]));
      rx = MAG_W'(r);
      m  = rx[MAG_W-1] ? MAG_W'(-rx) : MAG_W'(rx);
      ovf2_d   = ovf2_d | (|m[MAG_W-1:SQ_W]);
      mag_d[i] = m[SQ_W-1:0];
    end
  end

  always_comb begin
    logic [SQ_W-1:0] a0, a1;
    for (int i = 0; i < 3; i++) begin
      a0      = SQ_W'(mag_q[i][SQ_HALF-1:0]);
      a1      = SQ_W'(mag_q[i][SQ_W-1:SQ_HALF]);
      ll_d[i] = a0 * a0;
      lh_d[i] = a0 * a1;
      hh_d[i] = a1 * a1;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = ((2 * SQ_W)'(hh_q[i]) << SQ_W) + ((2 * SQ_W)'(lh_q[i]) << (SQ_HALF + 1))
              + (2 * SQ_W)'(ll_q[i]);
    end
    acc_d = ACC_W'(sq_q[0]) + ACC_W'(sq_q[1]) + ACC_W'(sq_q[2]);
  end

  always_comb begin
    logic [ACC_W-1:0] rounded;
    logic             rb, dsat;
    rb      = (FRAC_BITS > 0) ? acc_q[RBIT] : 1'b0;
    rounded = (acc_q >> (2 * FRAC_BITS)) + ACC_W'(rb);
    dsat    = ovf5_q || (|acc_q[ACC_W-1:2*SQ_W]) || (|rounded[ACC_W-1:SQ_W]);
    out_d.sqr_dist       = dsat ? {SQ_W{1'b1}} : rounded[SQ_W-1:0];
    out_d.param_t        = meta5_q.tq;
    out_d.zero_direction = meta5_q.zero_dir;
    out_d.saturated      = dsat || meta5_q.tsat;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      tpar1_q <= tpar_i;
      mag_q   <= mag_d;
      ovf2_q  <= ovf2_d;
      meta2_q <= tpar1_q.meta;
      ll_q    <= ll_d;
      lh_q    <= lh_d;
      hh_q    <= hh_d;
      ovf3_q  <= ovf2_q;
      meta3_q <= meta2_q;
      sq_q    <= sq_d;
      ovf4_q  <= ovf3_q;
      meta4_q <= meta3_q;
      acc_q   <= acc_d;
      ovf5_q  <= ovf4_q;
      meta5_q <= meta4_q;
      out_q   <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

/* rtl/point_to_line_ray_segment_sqr_distance.sv */
// ---------------------------------------------------------------------------
// Point to line, ray or segment squared distance
// Closest-point parameter and squared distance of a 3D point, fixed point.
// ---------------------------------------------------------------------------
// The input channel takes one query per transaction: a kind code, the point,
// the origin and the direction, all signed Q16.16. The output channel returns
// one transaction per query with the squared distance in unsigned Q32.32, the
// parameter in signed Q16.16 and the zero-direction and saturation flags.
// Both channels transfer when valid is high and stall is low.
// The pipeline has 22 register stages. One query enters every cycle while
// the output is not stalled; the rate is set by the pipelined restoring
// divider, which resolves three quotient bits per stage over eleven stages.
// Results leave in the order the queries came in. While the output holds a
// result and the receiver stalls, the whole pipeline holds and the input
// stalls; nothing is dropped or repeated.
// Reset clears only the stage valid bits; no output is valid after reset.
// ---------------------------------------------------------------------------
module point_to_line_ray_segment_sqr_distance import ptlrs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic [N_STAGES-1:0] valid_q, valid_d;
  logic                en;
  div_t                div_w [DIV_STAGES+1];
  tpar_t               tpar_w;

  assign en         = !(valid_q[N_STAGES-1] && out_stall_i);
  assign in_stall_o = !en;
  assign valid_d    = {valid_q[N_STAGES-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= valid_d;
    end
  end

  ptlrs_front u_front (
    .clk_i (clk_i),
    .en_i  (en),
    .in_i  (in_data_i),
    .div_o (div_w[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    ptlrs_div_stage u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .div_i (div_w[g]),
      .div_o (div_w[g+1])
    );
  end

  ptlrs_tclip u_tclip (
    .clk_i  (clk_i),
    .en_i   (en),
    .div_i  (div_w[DIV_STAGES]),
    .tpar_o (tpar_w)
  );

  ptlrs_dist u_dist (
    .clk_i  (clk_i),
    .en_i   (en),
    .tpar_i (tpar_w),
    .out_o  (out_data_o)
  );

  assign out_valid_o = valid_q[N_STAGES-1];

endmodule

/* rtl/ptlrs_checker.sv */
// ---------------------------------------------------------------------------
// Port checker
// Checks on the stall path, held results and the zero-direction result.
// ---------------------------------------------------------------------------
`include "point_to_line_ray_segment_sqr_distance_macros.svh"

module ptlrs_checker import ptlrs_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  `PTLRS_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  `PTLRS_ASSERT_NXT(a_held_result, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  `PTLRS_ASSERT_IMP(a_zero_dir_t, clk_i, rst_ni, out_valid_o && out_data_o.zero_direction, out_data_o.param_t == '0)

endmodule

bind point_to_line_ray_segment_sqr_distance ptlrs_checker u_checker (.*);
